FILE: src/chd_pkg.sv
// chd_pkg: shared types and constants for the crouch hysteresis detector
// no dependencies; used by chd_cfg_regs, chd_core and the top module by scoped names

package chd_pkg;

	localparam int CFG_IDX_BITS = 3;
	localparam int LIM_BITS     = 12;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH_MIN = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH_MAX = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_EXIT_HYST = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_PLAUS = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_PLAUS = 3'd6;

	// crouch mode codes; the unused code behaves as both enabled
	localparam logic [1:0] MODE_BUTTON   = 2'd0;
	localparam logic [1:0] MODE_PHYSICAL = 2'd1;
	localparam logic [1:0] MODE_BOTH     = 2'd2;

	// register values after reset
	localparam logic [1:0]          RST_MODE      = MODE_BOTH;
	localparam logic [LIM_BITS-1:0] RST_DEPTH     = 12'd400;
	localparam logic [LIM_BITS-1:0] RST_DEPTH_MIN = 12'd100;
	localparam logic [LIM_BITS-1:0] RST_DEPTH_MAX = 12'd1000;
	localparam logic [LIM_BITS-1:0] RST_EXIT_HYST = 12'd50;
	localparam int                  RST_MIN_PLAUS = 500;
	localparam int                  RST_MAX_PLAUS = 2500;

	// settings seen by the detector core
	typedef struct packed {
		logic [1:0]          mode;
		logic [LIM_BITS-1:0] depth;
		logic [LIM_BITS-1:0] hyst;
	} chd_cfg_t;

endpackage

FILE: src/chd_cfg_regs.sv
// chd_cfg_regs: configuration register file and crouch depth clamp
// depends on chd_pkg

module chd_cfg_regs #(
	parameter int HEIGHT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [chd_pkg::CFG_IDX_BITS-1:0]     wr_index,
	input  logic [HEIGHT_BITS-1:0]               wr_data,
	output chd_pkg::chd_cfg_t                    cfg,
	output logic signed [HEIGHT_BITS-1:0]        min_plaus,
	output logic signed [HEIGHT_BITS-1:0]        max_plaus
);

	logic [1:0]                   mode_q;
	logic [chd_pkg::LIM_BITS-1:0] depth_q;
	logic [chd_pkg::LIM_BITS-1:0] depth_min_q;
	logic [chd_pkg::LIM_BITS-1:0] depth_max_q;
	logic [chd_pkg::LIM_BITS-1:0] hyst_q;
	logic signed [HEIGHT_BITS-1:0] min_plaus_q;
	logic signed [HEIGHT_BITS-1:0] max_plaus_q;
	logic [chd_pkg::LIM_BITS-1:0] depth_lo;
	logic [chd_pkg::LIM_BITS-1:0] depth_clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= chd_pkg::RST_MODE;
			depth_q     <= chd_pkg::RST_DEPTH;
			depth_min_q <= chd_pkg::RST_DEPTH_MIN;
			depth_max_q <= chd_pkg::RST_DEPTH_MAX;
			hyst_q      <= chd_pkg::RST_EXIT_HYST;
			min_plaus_q <= HEIGHT_BITS'(chd_pkg::RST_MIN_PLAUS);
			max_plaus_q <= HEIGHT_BITS'(chd_pkg::RST_MAX_PLAUS);
		end else if (wr_en) begin
			case (wr_index)
				chd_pkg::REG_MODE:      mode_q      <= wr_data[1:0];
				chd_pkg::REG_DEPTH:     depth_q     <= wr_data[chd_pkg::LIM_BITS-1:0];
				chd_pkg::REG_DEPTH_MIN: depth_min_q <= wr_data[chd_pkg::LIM_BITS-1:0];
				chd_pkg::REG_DEPTH_MAX: depth_max_q <= wr_data[chd_pkg::LIM_BITS-1:0];
				chd_pkg::REG_EXIT_HYST: hyst_q      <= wr_data[chd_pkg::LIM_BITS-1:0];
				chd_pkg::REG_MIN_PLAUS: min_plaus_q <= wr_data;
				chd_pkg::REG_MAX_PLAUS: max_plaus_q <= wr_data;
				default: ;
			endcase
		end
	end

	// raise to the lower limit first, then the upper limit wins
	always_comb begin
		depth_lo      = (depth_q < depth_min_q) ? depth_min_q : depth_q;
		depth_clamped = (depth_lo > depth_max_q) ? depth_max_q : depth_lo;
	end

	assign cfg.mode  = mode_q;
	assign cfg.depth = depth_clamped;
	assign cfg.hyst  = hyst_q;
	assign min_plaus = min_plaus_q;
	assign max_plaus = max_plaus_q;

endmodule

FILE: src/chd_core.sv
// chd_core: detector state (baseline, physical flag, latch, counters) and next-word logic
// depends on chd_pkg; fed from the input stage, feeds the result stage

module chd_core #(
	parameter int HEIGHT_BITS = 16,
	parameter int COUNT_BITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  chd_pkg::chd_cfg_t             cfg,
	input  logic signed [HEIGHT_BITS-1:0] min_plaus,
	input  logic signed [HEIGHT_BITS-1:0] max_plaus,
	input  logic signed [HEIGHT_BITS-1:0] head,
	input  logic                          trk,
	input  logic                          game,
	input  logic                          level,
	input  logic                          edge_in,
	output logic                          active,
	output logic                          pressed,
	output logic                          rise,
	output logic                          fall,
	output logic                          base_known,
	output logic signed [HEIGHT_BITS-1:0] base,
	output logic signed [HEIGHT_BITS:0]   enter_lvl,
	output logic signed [HEIGHT_BITS:0]   exit_lvl,
	output logic                          phys,
	output logic                          latch,
	output logic [COUNT_BITS-1:0]         entries,
	output logic [COUNT_BITS-1:0]         exits
);

	localparam int W = HEIGHT_BITS + 2;

	logic                          base_valid_q;
	logic signed [HEIGHT_BITS-1:0] base_q;
	logic                          phys_q;
	logic                          latch_q;
	logic                          last_eff_q;
	logic [COUNT_BITS-1:0]         entry_q;
	logic [COUNT_BITS-1:0]         exit_q;

	logic                          phys_en;
	logic                          btn_en;
	logic                          plausible;
	logic                          changed;
	logic                          eff;
	logic                          base_valid_n;
	logic signed [HEIGHT_BITS-1:0] base_n;
	logic                          phys_n;
	logic                          latch_n;
	logic [COUNT_BITS-1:0]         entry_n;
	logic [COUNT_BITS-1:0]         exit_n;
	logic signed [W-1:0]           head_w;
	logic signed [W-1:0]           enter_w;
	logic signed [W-1:0]           exit_w;

	always_comb begin
		phys_en = (cfg.mode != chd_pkg::MODE_BUTTON);
		btn_en  = (cfg.mode != chd_pkg::MODE_PHYSICAL);

		if (btn_en && game && edge_in) begin
			latch_n = ~latch_q;
		end else if (!btn_en) begin
			latch_n = 1'b0;
		end else begin
			latch_n = latch_q;
		end

		plausible = game && trk && (head > min_plaus) && (head < max_plaus);

		base_valid_n = base_valid_q;
		base_n       = base_q;
		if (phys_en && plausible) begin
			if (!base_valid_q) begin
				base_valid_n = 1'b1;
				base_n       = head;
			end else if (!phys_q && !latch_n && (head > base_q)) begin
				base_n = head;
			end
		end

		head_w  = W'(head);
		enter_w = W'(base_n) - $signed({{(W-chd_pkg::LIM_BITS){1'b0}}, cfg.depth});
		exit_w  = enter_w + $signed({{(W-chd_pkg::LIM_BITS){1'b0}}, cfg.hyst});

		phys_n  = phys_q;
		changed = 1'b0;
		if (!phys_en) begin
			phys_n  = 1'b0;
			changed = phys_q;
		end else if (plausible) begin
			if (!phys_q && (head_w <= enter_w)) begin
				phys_n  = 1'b1;
				changed = 1'b1;
			end else if (phys_q && (head_w >= exit_w)) begin
				phys_n  = 1'b0;
				changed = 1'b1;
			end
		end

		entry_n = (changed && phys_n) ? entry_q + 1'b1 : entry_q;
		exit_n  = (changed && !phys_n) ? exit_q + 1'b1 : exit_q;
		eff     = phys_n || latch_n;

		active     = phys_en || (btn_en && level);
		pressed    = eff;
		rise       = !last_eff_q && eff;
		fall       = last_eff_q && !eff;
		base_known = base_valid_n;
		base       = base_n;
		enter_lvl  = base_valid_n ? enter_w[HEIGHT_BITS:0] : '0;
		exit_lvl   = base_valid_n ? exit_w[HEIGHT_BITS:0] : '0;
		phys       = phys_n;
		latch      = latch_n;
		entries    = entry_n;
		exits      = exit_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_valid_q <= 1'b0;
			base_q       <= '0;
			phys_q       <= 1'b0;
			latch_q      <= 1'b0;
			last_eff_q   <= 1'b0;
			entry_q      <= '0;
			exit_q       <= '0;
		end else if (advance) begin
			base_valid_q <= base_valid_n;
			base_q       <= base_n;
			phys_q       <= phys_n;
			latch_q      <= latch_n;
			last_eff_q   <= eff;
			entry_q      <= entry_n;
			exit_q       <= exit_n;
		end
	end

endmodule

FILE: src/crouch_hysteresis_detector_top.sv
// crouch_hysteresis_detector_top: input register, detector core, result register
// depends on chd_pkg, chd_cfg_regs and chd_core
//
//   channel | handshake                | payload
//   in      | in_valid / in_ready      | head_height_mm, tracking_ok, gameplay_on,
//           |                          | button_level, button_edge
//   out     | out_valid / out_ready    | crouch_active ... exit_total (twelve fields)
//   cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// one word per cycle sustained while out_ready stays high; words pass the input register, then the result register
// the detector state and result register move together once per word, so the
// state update loop in chd_core sets the one-word-per-cycle rate
// in_ready stays high while the input register is empty or the result register is free or being emptied
// a stalled out side holds one word in the result register and one in the input register
// cfg_ready is always high; reset clears both stage valids and all detector state

module crouch_hysteresis_detector_top #(
	parameter int HEIGHT_BITS = 16,
	parameter int COUNT_BITS  = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [HEIGHT_BITS-1:0]        head_height_mm,
	input  logic                                 tracking_ok,
	input  logic                                 gameplay_on,
	input  logic                                 button_level,
	input  logic                                 button_edge,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 crouch_active,
	output logic                                 crouch_pressed,
	output logic                                 crouch_rise,
	output logic                                 crouch_fall,
	output logic                                 baseline_known,
	output logic signed [HEIGHT_BITS-1:0]        baseline_mm,
	output logic signed [HEIGHT_BITS:0]          enter_level_mm,
	output logic signed [HEIGHT_BITS:0]          exit_level_mm,
	output logic                                 physical_state,
	output logic                                 latch_state,
	output logic [COUNT_BITS-1:0]                entry_total,
	output logic [COUNT_BITS-1:0]                exit_total,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [chd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [HEIGHT_BITS-1:0]               cfg_data
);

	chd_pkg::chd_cfg_t             cfg;
	logic signed [HEIGHT_BITS-1:0] min_plaus;
	logic signed [HEIGHT_BITS-1:0] max_plaus;

	logic                          valid_s1;
	logic signed [HEIGHT_BITS-1:0] head_s1;
	logic                          trk_s1;
	logic                          game_s1;
	logic                          level_s1;
	logic                          edge_s1;
	logic                          valid_s2;
	logic                          advance;
	logic                          take_in;

	logic                          active_c;
	logic                          pressed_c;
	logic                          rise_c;
	logic                          fall_c;
	logic                          known_c;
	logic signed [HEIGHT_BITS-1:0] base_c;
	logic signed [HEIGHT_BITS:0]   enter_c;
	logic signed [HEIGHT_BITS:0]   exit_c;
	logic                          phys_c;
	logic                          latch_c;
	logic [COUNT_BITS-1:0]         entries_c;
	logic [COUNT_BITS-1:0]         exits_c;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign take_in   = in_valid && in_ready;

	chd_cfg_regs #(
		.HEIGHT_BITS(HEIGHT_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.min_plaus(min_plaus),
		.max_plaus(max_plaus)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			head_s1  <= head_height_mm;
			trk_s1   <= tracking_ok;
			game_s1  <= gameplay_on;
			level_s1 <= button_level;
			edge_s1  <= button_edge;
		end
	end

	chd_core #(
		.HEIGHT_BITS(HEIGHT_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.cfg       (cfg),
		.min_plaus (min_plaus),
		.max_plaus (max_plaus),
		.head      (head_s1),
		.trk       (trk_s1),
		.game      (game_s1),
		.level     (level_s1),
		.edge_in   (edge_s1),
		.active    (active_c),
		.pressed   (pressed_c),
		.rise      (rise_c),
		.fall      (fall_c),
		.base_known(known_c),
		.base      (base_c),
		.enter_lvl (enter_c),
		.exit_lvl  (exit_c),
		.phys      (phys_c),
		.latch     (latch_c),
		.entries   (entries_c),
		.exits     (exits_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= advance || (valid_s2 && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			crouch_active  <= active_c;
			crouch_pressed <= pressed_c;
			crouch_rise    <= rise_c;
			crouch_fall    <= fall_c;
			baseline_known <= known_c;
			baseline_mm    <= base_c;
			enter_level_mm <= enter_c;
			exit_level_mm  <= exit_c;
			physical_state <= phys_c;
			latch_state    <= latch_c;
			entry_total    <= entries_c;
			exit_total     <= exits_c;
		end
	end

	assign out_valid = valid_s2;

endmodule

FILE: src/chd_checker.sv
// chd_checker: port-level checks on the crouch hysteresis detector results
// depends on crouch_hysteresis_detector_top; attached by the bind below

module chd_checker #(
	parameter int HEIGHT_BITS = 16,
	parameter int COUNT_BITS  = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          crouch_pressed,
	input logic                          crouch_rise,
	input logic                          crouch_fall,
	input logic                          baseline_known,
	input logic signed [HEIGHT_BITS:0]   enter_level_mm,
	input logic signed [HEIGHT_BITS:0]   exit_level_mm,
	input logic                          physical_state,
	input logic                          latch_state,
	input logic [COUNT_BITS-1:0]         entry_total
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(crouch_pressed)
			&& $stable(entry_total) && $stable(enter_level_mm))
		else $error("result word changed while stalled");

	// edges agree with the effective crouch
	a_edges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(crouch_rise && crouch_fall)
			&& (crouch_pressed == (physical_state || latch_state))
			&& (!crouch_rise || crouch_pressed) && (!crouch_fall || !crouch_pressed))
		else $error("crouch edges inconsistent with effective crouch");

	// levels read zero until a baseline exists
	a_levels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !baseline_known |-> enter_level_mm == '0 && exit_level_mm == '0)
		else $error("levels non-zero without a baseline");

	// a physical crouch needs a baseline
	a_phys: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && physical_state |-> baseline_known)
		else $error("physical crouch without a baseline");

endmodule

bind crouch_hysteresis_detector_top chd_checker #(
	.HEIGHT_BITS(HEIGHT_BITS),
	.COUNT_BITS (COUNT_BITS)
) u_chd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.crouch_pressed(crouch_pressed),
	.crouch_rise   (crouch_rise),
	.crouch_fall   (crouch_fall),
	.baseline_known(baseline_known),
	.enter_level_mm(enter_level_mm),
	.exit_level_mm (exit_level_mm),
	.physical_state(physical_state),
	.latch_state   (latch_state),
	.entry_total   (entry_total)
);
